// ----- hdl/gbnf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbnf_pkg
// Shared types and constants of the 4bpp glyph blitter.
// ----------------------------------------------------------------------------
package gbnf_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 8192;
  localparam int unsigned FONT_BYTES_DEF  = 8192;

  localparam logic [7:0] CHAR_FIRST = 8'd32;   // ' '
  localparam logic [7:0] CHAR_LAST  = 8'd126;

  localparam logic [7:0] RST_DISP_W = 8'd128;
  localparam logic [7:0] RST_DISP_H = 8'd128;
  localparam logic [5:0] RST_FONT_W = 6'd8;
  localparam logic [5:0] RST_FONT_H = 6'd8;
  localparam logic [3:0] RST_SCALE  = 4'd1;
  localparam logic [3:0] RST_FG     = 4'd15;
  localparam logic [3:0] RST_BG     = 4'd0;
  localparam logic [1:0] RST_MODE   = 2'd0;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_DRAW   = 3'd1,
    CMD_SETCUR = 3'd2,
    CMD_PRINT  = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OFFSCREEN = 2'd1,
    ST_UNPRINT   = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_DISP_W = 3'd0,
    REG_DISP_H = 3'd1,
    REG_FONT_W = 3'd2,
    REG_FONT_H = 3'd3,
    REG_SCALE  = 3'd4,
    REG_FG     = 3'd5,
    REG_BG     = 3'd6,
    REG_MODE   = 3'd7
  } reg_e;

endpackage

// ----- hdl/gbnf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbnf channel interfaces
// Command, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface gbnf_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  x_pos;
  logic [7:0]  y_pos;
  logic [7:0]  char_code;
  logic [12:0] font_addr;
  logic [7:0]  font_byte;
  logic [12:0] fb_addr;
  modport source (output valid, cmd, x_pos, y_pos, char_code, font_addr, font_byte,
                  fb_addr, input ready);
  modport sink (input valid, cmd, x_pos, y_pos, char_code, font_addr, font_byte,
                fb_addr, output ready);
endinterface

interface gbnf_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] read_data;
  logic [7:0] cursor_x;
  logic [7:0] cursor_y;
  modport source (output valid, status, read_data, cursor_x, cursor_y, input ready);
  modport sink (input valid, status, read_data, cursor_x, cursor_y, output ready);
endinterface

interface gbnf_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/glyph_blitter_nibble_framebuffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_blitter_nibble_framebuffer
// Bitmap font renderer into a 4bpp framebuffer (two pixels per byte).
// ----------------------------------------------------------------------------
// Usage:
//  cmd_ch carries one command per transaction; rsp_ch returns exactly one
//  response per command (status, read data, cursor after the command).
//  cfg_ch writes the registers at any time and is always ready; write it
//  only while no command is in flight.
//  Font and framebuffer bytes live in two synchronous simple dual-port RAMs.
//  A glyph draw first forms the base address (product and modulo reduction),
//  then does one font read per glyph pixel, one framebuffer read per scaled
//  pixel and one write-back per scaled pixel that gets painted.
//  After reset the framebuffer is cleared, one byte per cycle; cmd_ch is
//  not ready meanwhile.
//  The response sits in an output register; a stalled receiver holds it
//  while the next command is taken and worked on, and that command's
//  response waits until the register frees up.
// ----------------------------------------------------------------------------
module glyph_blitter_nibble_framebuffer #(
  parameter int unsigned FRAME_BYTES = gbnf_pkg::FRAME_BYTES_DEF,
  parameter int unsigned FONT_BYTES  = gbnf_pkg::FONT_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbnf_cmd_if.sink   cmd_ch,
  gbnf_rsp_if.source rsp_ch,
  gbnf_cfg_if.sink   cfg_ch
);

  localparam int unsigned FB_AW = $clog2(FRAME_BYTES);
  localparam int unsigned FT_AW = $clog2(FONT_BYTES);

  typedef enum logic [12:0] {
    S_CLR    = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_EXEC   = 13'b0000000000100,
    S_PRINT2 = 13'b0000000001000,
    S_MUL1   = 13'b0000000010000,
    S_MUL2   = 13'b0000000100000,
    S_RED    = 13'b0000001000000,
    S_FWR    = 13'b0000010000000,
    S_FRD    = 13'b0000100000000,
    S_PRD    = 13'b0001000000000,
    S_PWR    = 13'b0010000000000,
    S_READ   = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_e;

  state_e state_q;

  logic [7:0] dw_q, dh_q;
  logic [5:0] fw_q, fh_q;
  logic [3:0] sc_q, fg_q, bg_q;
  logic [1:0] mode_q;

  gbnf_pkg::cmd_e cmd_q;
  logic [7:0]  xp_q, yp_q, code_q, fbyte_q;
  logic [12:0] faddr_q, rdaddr_q;

  logic [7:0] col_q, row_q, lstart_q;
  logic       halted_q;

  logic [7:0]  gx_q, gy_q, xb_q, yb_q;
  logic [12:0] prod_q;
  logic [15:0] rem_q, raddr_q;
  logic [2:0]  k_q;
  logic [5:0]  grow_q, gcol_q;
  logic [3:0]  p_q, q_q;

  logic       ov_q;
  logic [1:0] st_q, ost_q;
  logic [7:0] rd_q, ord_q, ocx_q, ocy_q;
  logic [FB_AW-1:0] clr_q;

  logic [7:0] fr_mem [FRAME_BYTES];
  logic [7:0] ft_mem [FONT_BYTES];
  logic [7:0] fr_rd_q, ft_rd_q;

  // --------------------------------------------------------------------------
  logic        printable, over, zero_size, adv;
  logic [3:0]  rb;
  logic signed [9:0] limit;
  logic [23:0] sub_v;
  logic [15:0] rem_nx;
  logic [16:0] byte_sum, ft_ra_full;
  logic [7:0]  px, py, grey, new_byte;
  logic [15:0] idx;
  logic        pix_ok, gbit, pix_en;
  logic [15:0] rdaddr_ext;
  logic        rd_inrange;
  logic        q_last, p_last, col_last, row_last;

  always_comb begin
    printable = (code_q >= gbnf_pkg::CHAR_FIRST) && (code_q <= gbnf_pkg::CHAR_LAST);
    limit     = $signed({2'b00, dw_q}) - $signed({4'b0000, fw_q});
    over      = $signed({2'b00, col_q}) > limit;
    zero_size = (fw_q == 6'd0) || (fh_q == 6'd0) || (sc_q == 4'd0);
    rb        = 4'((7'(fw_q) + 7'd7) >> 3);
    sub_v     = 24'(FONT_BYTES) << k_q;
    rem_nx    = (24'(rem_q) >= sub_v) ? 16'(24'(rem_q) - sub_v) : rem_q;
    byte_sum  = 17'(raddr_q) + 17'(gcol_q[5:3]);
    ft_ra_full = (byte_sum >= 17'(FONT_BYTES)) ? byte_sum - 17'(FONT_BYTES) : byte_sum;
    px        = xb_q + 8'(p_q);
    py        = yb_q + 8'(q_q);
    idx       = 16'(16'(py) * 16'(dw_q[7:1])) + 16'(px[7:1]);
    pix_ok    = (px < dw_q) && (py < dh_q) && ({1'b0, idx} < 17'(FRAME_BYTES));
    gbit      = ft_rd_q[3'd7 - gcol_q[2:0]];
    pix_en    = pix_ok && (gbit || mode_q[0]);
    grey      = gbit ? {4'd0, fg_q} : {4'd0, bg_q};
    new_byte  = px[0] ? {fr_rd_q[7:4], grey[3:0]} : {grey[3:0], fr_rd_q[3:0]};
    rdaddr_ext = 16'(rdaddr_q);
    rd_inrange = 17'(rdaddr_q) < 17'(FRAME_BYTES);
    q_last    = (5'(q_q) + 5'd1) >= 5'(sc_q);
    p_last    = (5'(p_q) + 5'd1) >= 5'(sc_q);
    col_last  = (7'(gcol_q) + 7'd1) >= 7'(fw_q);
    row_last  = (7'(grow_q) + 7'd1) >= 7'(fh_q);
    adv       = ((state_q == S_PRD) && !pix_en) || (state_q == S_PWR);
  end

  // Framebuffer RAM
  logic             fr_we;
  logic [FB_AW-1:0] fr_wa, fr_ra;
  logic [7:0]       fr_wd;

  always_comb begin
    fr_we = (state_q == S_CLR) || (state_q == S_PWR);
    fr_wa = (state_q == S_CLR) ? clr_q : idx[FB_AW-1:0];
    fr_wd = (state_q == S_CLR) ? 8'd0 : new_byte;
    fr_ra = (state_q == S_PRD) ? idx[FB_AW-1:0] : rdaddr_ext[FB_AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      fr_mem[fr_wa] <= fr_wd;
    end
    fr_rd_q <= fr_mem[fr_ra];
  end

  // Font RAM
  always_ff @(posedge clk_i) begin
    if (state_q == S_FWR) begin
      ft_mem[rem_q[FT_AW-1:0]] <= fbyte_q;
    end
    ft_rd_q <= ft_mem[ft_ra_full[FT_AW-1:0]];
  end

  // Registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dw_q   <= gbnf_pkg::RST_DISP_W;
      dh_q   <= gbnf_pkg::RST_DISP_H;
      fw_q   <= gbnf_pkg::RST_FONT_W;
      fh_q   <= gbnf_pkg::RST_FONT_H;
      sc_q   <= gbnf_pkg::RST_SCALE;
      fg_q   <= gbnf_pkg::RST_FG;
      bg_q   <= gbnf_pkg::RST_BG;
      mode_q <= gbnf_pkg::RST_MODE;
    end else if (cfg_ch.valid) begin
      unique case (gbnf_pkg::reg_e'(cfg_ch.index))
        gbnf_pkg::REG_DISP_W: dw_q   <= cfg_ch.data;
        gbnf_pkg::REG_DISP_H: dh_q   <= cfg_ch.data;
        gbnf_pkg::REG_FONT_W: fw_q   <= cfg_ch.data[5:0];
        gbnf_pkg::REG_FONT_H: fh_q   <= cfg_ch.data[5:0];
        gbnf_pkg::REG_SCALE:  sc_q   <= cfg_ch.data[3:0];
        gbnf_pkg::REG_FG:     fg_q   <= cfg_ch.data[3:0];
        gbnf_pkg::REG_BG:     bg_q   <= cfg_ch.data[3:0];
        gbnf_pkg::REG_MODE:   mode_q <= cfg_ch.data[1:0];
        default: ;
      endcase
    end
  end

  assign cmd_ch.ready     = (state_q == S_IDLE);
  assign rsp_ch.valid     = ov_q;
  assign rsp_ch.status    = ost_q;
  assign rsp_ch.read_data = ord_q;
  assign rsp_ch.cursor_x  = ocx_q;
  assign rsp_ch.cursor_y  = ocy_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      col_q    <= 8'd0;
      row_q    <= 8'd0;
      lstart_q <= 8'd0;
      halted_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (ov_q && rsp_ch.ready && (state_q != S_DONE)) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == FRAME_BYTES - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_ch.valid) begin
            cmd_q    <= gbnf_pkg::cmd_e'(cmd_ch.cmd);
            xp_q     <= cmd_ch.x_pos;
            yp_q     <= cmd_ch.y_pos;
            code_q   <= cmd_ch.char_code;
            faddr_q  <= cmd_ch.font_addr;
            fbyte_q  <= cmd_ch.font_byte;
            rdaddr_q <= cmd_ch.fb_addr;
            st_q     <= gbnf_pkg::ST_DONE;
            rd_q     <= 8'd0;
            state_q  <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd_q)
            gbnf_pkg::CMD_LOAD: begin
              rem_q   <= 16'(faddr_q);
              k_q     <= 3'd7;
              state_q <= S_RED;
            end
            gbnf_pkg::CMD_DRAW: begin
              if ((xp_q > dw_q) || (yp_q > dh_q)) begin
                st_q    <= gbnf_pkg::ST_OFFSCREEN;
                state_q <= S_DONE;
              end else if (!printable) begin
                st_q    <= gbnf_pkg::ST_UNPRINT;
                state_q <= S_DONE;
              end else begin
                gx_q    <= xp_q;
                gy_q    <= yp_q;
                state_q <= zero_size ? S_DONE : S_MUL1;
              end
            end
            gbnf_pkg::CMD_SETCUR: begin
              col_q    <= xp_q;
              row_q    <= yp_q;
              lstart_q <= xp_q;
              halted_q <= 1'b0;
              state_q  <= S_DONE;
            end
            gbnf_pkg::CMD_PRINT: begin
              if (!printable) begin
                st_q    <= gbnf_pkg::ST_UNPRINT;
                state_q <= S_DONE;
              end else if (halted_q) begin
                st_q    <= gbnf_pkg::ST_OVERFLOW;
                state_q <= S_DONE;
              end else if (over && !mode_q[1]) begin
                halted_q <= 1'b1;
                st_q     <= gbnf_pkg::ST_OVERFLOW;
                state_q  <= S_DONE;
              end else begin
                if (over) begin
                  col_q <= lstart_q;
                  row_q <= row_q + 8'(10'(fh_q) * 10'(sc_q));
                end
                state_q <= S_PRINT2;
              end
            end
            gbnf_pkg::CMD_READ: state_q <= S_READ;
            default:            state_q <= S_DONE;
          endcase
        end
        S_PRINT2: begin
          gx_q  <= col_q;
          gy_q  <= row_q;
          col_q <= col_q + 8'(10'(fw_q) * 10'(sc_q));
          if ((col_q > dw_q) || (row_q > dh_q)) begin
            st_q    <= gbnf_pkg::ST_OFFSCREEN;
            state_q <= S_DONE;
          end else begin
            state_q <= zero_size ? S_DONE : S_MUL1;
          end
        end
        S_MUL1: begin
          prod_q  <= 13'(7'(code_q - gbnf_pkg::CHAR_FIRST) * 13'(fh_q));
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          rem_q   <= 16'(prod_q) * 16'(rb);
          k_q     <= 3'd7;
          state_q <= S_RED;
        end
        S_RED: begin
          rem_q <= rem_nx;
          k_q   <= k_q - 3'd1;
          if (k_q == 3'd0) begin
            if (cmd_q == gbnf_pkg::CMD_LOAD) begin
              state_q <= S_FWR;
            end else begin
              raddr_q <= rem_nx;
              grow_q  <= 6'd0;
              gcol_q  <= 6'd0;
              p_q     <= 4'd0;
              q_q     <= 4'd0;
              xb_q    <= gx_q;
              yb_q    <= gy_q;
              state_q <= S_FRD;
            end
          end
        end
        S_FWR:  state_q <= S_DONE;
        S_FRD:  state_q <= S_PRD;
        S_PRD: begin
          if (pix_en) begin
            state_q <= S_PWR;
          end
        end
        S_PWR:  ; // next state comes from the pixel walk
        S_READ: begin
          rd_q    <= rd_inrange ? fr_rd_q : 8'd0;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!ov_q || rsp_ch.ready) begin
            ov_q    <= 1'b1;
            ost_q   <= st_q;
            ord_q   <= rd_q;
            ocx_q   <= col_q;
            ocy_q   <= row_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // Scaled pixel walk: row, column, x repeat, y repeat
      if (adv) begin
        if (!q_last) begin
          q_q     <= q_q + 4'd1;
          state_q <= S_PRD;
        end else begin
          q_q <= 4'd0;
          if (!p_last) begin
            p_q     <= p_q + 4'd1;
            state_q <= S_PRD;
          end else begin
            p_q <= 4'd0;
            if (!col_last) begin
              gcol_q  <= gcol_q + 6'd1;
              xb_q    <= xb_q + 8'(sc_q);
              state_q <= S_FRD;
            end else begin
              gcol_q <= 6'd0;
              xb_q   <= gx_q;
              if (!row_last) begin
                grow_q  <= grow_q + 6'd1;
                yb_q    <= yb_q + 8'(sc_q);
                raddr_q <= ((17'(raddr_q) + 17'(rb)) >= 17'(FONT_BYTES)) ?
                           16'(17'(raddr_q) + 17'(rb) - 17'(FONT_BYTES)) :
                           raddr_q + 16'(rb);
                state_q <= S_FRD;
              end else begin
                state_q <= S_DONE;
              end
            end
          end
        end
      end
    end
  end

endmodule
